>>> sv/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg: shared definitions for the heterodyne phase-shift pixel core
// Default sizes, step-count and frequency codes, and the CORDIC angle table.
// ----------------------------------------------------------------------------
package psh_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int PHASE_BITS_DEF  = 16;
	localparam int CORDIC_ITER_DEF = 16;

	localparam int ATAN_LEN = 24;

	// atan(2^-i), full turn = 2^32
	localparam longint ATAN_TURN32 [ATAN_LEN] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef logic [2:0] steps_t;
	localparam steps_t STEPS_THREE = 3'd3;
	localparam steps_t STEPS_FOUR  = 3'd4;
	localparam steps_t STEPS_FIVE  = 3'd5;
	localparam steps_t STEPS_SIX   = 3'd6;
	localparam steps_t STEPS_RESET = STEPS_FOUR;

	typedef logic [1:0] freq_t;
	localparam freq_t FREQ_ZERO  = 2'd0;
	localparam freq_t FREQ_ONE   = 2'd1;
	localparam freq_t FREQ_TWO   = 2'd2;
	localparam freq_t FREQ_THREE = 2'd3;

	// Table angle rounded half up to a binary angle where 2^pbits is a full turn
	function automatic longint atan_code(input int idx, input int pbits);
		longint r;
		if (idx >= ATAN_LEN) begin
			r = 0;
		end else begin
			r = (ATAN_TURN32[idx] + (longint'(1) <<< (31 - pbits))) >>> (32 - pbits);
		end
		return r;
	endfunction

endpackage

>>> sv/phase_shift_heterodyne_pixel_core.sv
// ----------------------------------------------------------------------------
// phase_shift_heterodyne_pixel_core: wrapped phase and heterodyne per pixel
// Per-pixel atan2 of phase-shifted samples through a row of CORDIC cells,
// with heterodyne differences of three pattern frequencies.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one sample set per transaction, pixel-major,
//   frequency 0, 1 then 2 (tuser). The master stream returns one result per
//   transaction: the wrapped phase and, on frequency 2, the three heterodyne
//   differences with the diffs_valid flag in tuser.
//   cfg_valid/cfg_data write the step count (3 to 6); write it only while no
//   transaction is in flight. cfg_ready is always high.
//   Registered path from input transaction to result: formula stage, one
//   cell per CORDIC iteration, wrap, pair differences, output register.
//   Throughput: one transaction per cycle while the receiver does not stall,
//   set by the fully pipelined cell row.
//   Reset clears all stage valid bits, the stored phases of frequencies 0
//   and 1, and sets the step count to 4.
//   When the receiver stalls, results collect toward the output register;
//   s_tready stays high while any stage of the row still holds a bubble,
//   and drops once the row is full.
// ----------------------------------------------------------------------------
module phase_shift_heterodyne_pixel_core #(
	parameter int SAMPLE_BITS       = psh_pkg::SAMPLE_BITS_DEF,
	parameter int PHASE_BITS        = psh_pkg::PHASE_BITS_DEF,
	parameter int CORDIC_ITERATIONS = psh_pkg::CORDIC_ITER_DEF,
	localparam int IN_W  = ((6 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((4 * (PHASE_BITS + 1) + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  psh_pkg::steps_t   cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	// sample_one, sample_two, sample_three, sample_four, sample_five, sample_six
	input  logic [IN_W-1:0]   s_tdata,
	// freq_index
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// wrapped_phase, diff_one_two, diff_two_three, diff_all
	output logic [OUT_W-1:0]  m_tdata,
	// diffs_valid
	output logic              m_tuser
);

	localparam int S  = SAMPLE_BITS;
	localparam int N  = CORDIC_ITERATIONS;
	localparam int PW = PHASE_BITS + 1;
	localparam int W  = SAMPLE_BITS + 4 + CORDIC_ITERATIONS;
	localparam int ZW = PHASE_BITS + 2;

	psh_pkg::steps_t      step_count_q;

	logic                 valid_c [0:N];
	logic                 ready_c [0:N];
	logic signed [W-1:0]  x_c     [0:N];
	logic signed [W-1:0]  y_c     [0:N];
	logic signed [ZW-1:0] z_c     [0:N];
	logic                 zero_c  [0:N];
	psh_pkg::freq_t       freq_c  [0:N];

	logic [PW-1:0] phase_o, d12_o, d23_o, dall_o;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= psh_pkg::STEPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_count_q <= cfg_data;
		end
	end

	psh_prep #(
		.SAMPLE_BITS       (SAMPLE_BITS),
		.PHASE_BITS        (PHASE_BITS),
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_count (step_count_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.s1         (s_tdata[0*S +: S]),
		.s2         (s_tdata[1*S +: S]),
		.s3         (s_tdata[2*S +: S]),
		.s4         (s_tdata[3*S +: S]),
		.s5         (s_tdata[4*S +: S]),
		.s6         (s_tdata[5*S +: S]),
		.freq       (s_tuser),
		.out_ready  (ready_c[0]),
		.out_valid  (valid_c[0]),
		.x_s1       (x_c[0]),
		.y_s1       (y_c[0]),
		.z_s1       (z_c[0]),
		.zero_s1    (zero_c[0]),
		.freq_s1    (freq_c[0])
	);

	for (genvar k = 0; k < N; k++) begin : g_cell
		psh_cordic_cell #(
			.W          (W),
			.ZW         (ZW),
			.PHASE_BITS (PHASE_BITS),
			.IDX        (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[k]),
			.in_ready  (ready_c[k]),
			.x_in      (x_c[k]),
			.y_in      (y_c[k]),
			.z_in      (z_c[k]),
			.zero_in   (zero_c[k]),
			.freq_in   (freq_c[k]),
			.out_ready (ready_c[k+1]),
			.out_valid (valid_c[k+1]),
			.x_q       (x_c[k+1]),
			.y_q       (y_c[k+1]),
			.z_q       (z_c[k+1]),
			.zero_q    (zero_c[k+1]),
			.freq_q    (freq_c[k+1])
		);
	end

	psh_hetero #(
		.PHASE_BITS (PHASE_BITS)
	) u_hetero (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_c[N]),
		.in_ready  (ready_c[N]),
		.z_in      (z_c[N]),
		.zero_in   (zero_c[N]),
		.freq_in   (freq_c[N]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.phase_s3  (phase_o),
		.d12_s3    (d12_o),
		.d23_s3    (d23_o),
		.dall_s3   (dall_o),
		.dv_s3     (m_tuser)
	);

	assign m_tdata = {{(OUT_W - 4*PW){1'b0}}, dall_o, d23_o, d12_o, phase_o};

endmodule

>>> sv/psh_prep.sv
// ----------------------------------------------------------------------------
// psh_prep: numerator/denominator formation and quadrant pre-rotation
// Builds y and x from the samples per step count, turns vectors with x < 0
// by a quarter turn and scales them up for the CORDIC row.
// ----------------------------------------------------------------------------
module psh_prep #(
	parameter int SAMPLE_BITS       = psh_pkg::SAMPLE_BITS_DEF,
	parameter int PHASE_BITS        = psh_pkg::PHASE_BITS_DEF,
	parameter int CORDIC_ITERATIONS = psh_pkg::CORDIC_ITER_DEF,
	localparam int NW = SAMPLE_BITS + 2,
	localparam int W  = NW + 2 + CORDIC_ITERATIONS,
	localparam int ZW = PHASE_BITS + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  psh_pkg::steps_t        step_count,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] s1,
	input  logic [SAMPLE_BITS-1:0] s2,
	input  logic [SAMPLE_BITS-1:0] s3,
	input  logic [SAMPLE_BITS-1:0] s4,
	input  logic [SAMPLE_BITS-1:0] s5,
	input  logic [SAMPLE_BITS-1:0] s6,
	input  psh_pkg::freq_t         freq,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic signed [W-1:0]    x_s1,
	output logic signed [W-1:0]    y_s1,
	output logic signed [ZW-1:0]   z_s1,
	output logic                   zero_s1,
	output psh_pkg::freq_t         freq_s1
);

	localparam logic signed [ZW-1:0] HALF_PI = {{3{1'b0}}, 1'b1, {(PHASE_BITS-2){1'b0}}};

	logic signed [NW-1:0] e1, e2, e3, e4, e5, e6;
	logic signed [NW-1:0] xn, yn, xr, yr;
	logic signed [ZW-1:0] zr;
	psh_pkg::steps_t      eff;
	logic                 valid_s1;

	assign e1 = $signed({2'b00, s1});
	assign e2 = $signed({2'b00, s2});
	assign e3 = $signed({2'b00, s3});
	assign e4 = $signed({2'b00, s4});
	assign e5 = $signed({2'b00, s5});
	assign e6 = $signed({2'b00, s6});

	always_comb begin
		if (step_count < psh_pkg::STEPS_THREE) begin
			eff = psh_pkg::STEPS_THREE;
		end else if (step_count > psh_pkg::STEPS_SIX) begin
			eff = psh_pkg::STEPS_SIX;
		end else begin
			eff = step_count;
		end
	end

	always_comb begin
		case (eff)
			psh_pkg::STEPS_THREE: begin
				yn = (e2 <<< 1) - e1 - e3;
				xn = e3 - e1;
			end
			psh_pkg::STEPS_FOUR: begin
				yn = e4 - e2;
				xn = e1 - e3;
			end
			psh_pkg::STEPS_FIVE: begin
				yn = (e2 - e4) <<< 1;
				xn = (e3 <<< 1) - e1 - e5;
			end
			default: begin
				yn = e2 + e6 - (e4 <<< 1);
				xn = (e3 <<< 1) - e1 - e5;
			end
		endcase
	end

	// turn the left half-plane into the right one
	always_comb begin
		xr = xn;
		yr = yn;
		zr = '0;
		if (xn[NW-1]) begin
			if (!yn[NW-1]) begin
				xr = yn;
				yr = -xn;
				zr = HALF_PI;
			end else begin
				xr = -yn;
				yr = xn;
				zr = -HALF_PI;
			end
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1    <= {{2{xr[NW-1]}}, xr, {CORDIC_ITERATIONS{1'b0}}};
			y_s1    <= {{2{yr[NW-1]}}, yr, {CORDIC_ITERATIONS{1'b0}}};
			z_s1    <= zr;
			zero_s1 <= (xn == '0) && (yn == '0);
			freq_s1 <= freq;
		end
	end

endmodule

>>> sv/psh_cordic_cell.sv
// ----------------------------------------------------------------------------
// psh_cordic_cell: one vectoring CORDIC iteration with its own register
// Rotates toward y = 0 by atan(2^-IDX) and passes the vector on.
// ----------------------------------------------------------------------------
module psh_cordic_cell #(
	parameter int W          = 32,
	parameter int ZW         = 18,
	parameter int PHASE_BITS = psh_pkg::PHASE_BITS_DEF,
	parameter int IDX        = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [W-1:0]  x_in,
	input  logic signed [W-1:0]  y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic                 zero_in,
	input  psh_pkg::freq_t       freq_in,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic signed [W-1:0]  x_q,
	output logic signed [W-1:0]  y_q,
	output logic signed [ZW-1:0] z_q,
	output logic                 zero_q,
	output psh_pkg::freq_t       freq_q
);

	localparam logic signed [ZW-1:0] ANG = ZW'(psh_pkg::atan_code(IDX, PHASE_BITS));

	logic signed [W-1:0]  dx, dy, x_n, y_n;
	logic signed [ZW-1:0] z_n;
	logic                 valid_q;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	always_comb begin
		if (!y_in[W-1]) begin
			x_n = x_in + dx;
			y_n = y_in - dy;
			z_n = z_in + ANG;
		end else begin
			x_n = x_in - dx;
			y_n = y_in + dy;
			z_n = z_in - ANG;
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_q    <= x_n;
			y_q    <= y_n;
			z_q    <= z_n;
			zero_q <= zero_in;
			freq_q <= freq_in;
		end
	end

endmodule

>>> sv/psh_hetero.sv
// ----------------------------------------------------------------------------
// psh_hetero: phase wrap, per-pixel phase store and heterodyne differences
// Three stages: wrap the angle, form the pair differences while storing
// frequency 0 and 1 phases, then form the combined difference into the
// output register.
// ----------------------------------------------------------------------------
module psh_hetero #(
	parameter int PHASE_BITS = psh_pkg::PHASE_BITS_DEF,
	localparam int ZW = PHASE_BITS + 2,
	localparam int DW = PHASE_BITS + 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [ZW-1:0]   z_in,
	input  logic                   zero_in,
	input  psh_pkg::freq_t         freq_in,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [PHASE_BITS:0]    phase_s3,
	output logic [PHASE_BITS:0]    d12_s3,
	output logic [PHASE_BITS:0]    d23_s3,
	output logic [PHASE_BITS:0]    dall_s3,
	output logic                   dv_s3
);

	localparam logic signed [ZW-1:0] PI_Z =
		{{(ZW-PHASE_BITS){1'b0}}, 1'b1, {(PHASE_BITS-1){1'b0}}};
	localparam logic signed [ZW-1:0] TWO_PI_Z = PI_Z <<< 1;
	localparam logic signed [DW-1:0] TWO_PI_D =
		{{(DW-PHASE_BITS-1){1'b0}}, 1'b1, {PHASE_BITS{1'b0}}};

	function automatic logic [PHASE_BITS:0] hdiff(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] dw;
		d  = a - b;
		dw = d + TWO_PI_D;
		if (a > b) begin
			return d[PHASE_BITS:0];
		end else begin
			return dw[PHASE_BITS:0];
		end
	endfunction

	logic                        v_s1, v_s2, v_s3;
	logic                        rdy1, rdy2, rdy3;
	logic signed [ZW-1:0]        zw;
	logic signed [PHASE_BITS:0]  phase_s1, phase_s2;
	psh_pkg::freq_t              freq_s1;
	logic signed [PHASE_BITS:0]  pf0_q, pf1_q;
	logic [PHASE_BITS:0]         d12_s2, d23_s2;
	logic                        dv_s2;
	logic [PHASE_BITS:0]         d12_n, d23_n;
	logic                        dv_n;

	assign rdy3      = !v_s3 || out_ready;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign in_ready  = rdy1;
	assign out_valid = v_s3;

	// fold overshoot back into (-pi, pi]
	always_comb begin
		zw = z_in;
		if (z_in > PI_Z) begin
			zw = z_in - TWO_PI_Z;
		end else if (z_in <= -PI_Z) begin
			zw = z_in + TWO_PI_Z;
		end
	end

	always_comb begin
		d12_n = '0;
		d23_n = '0;
		dv_n  = 1'b0;
		if (freq_s1 == psh_pkg::FREQ_TWO) begin
			d12_n = hdiff(DW'(pf0_q), DW'(pf1_q));
			d23_n = hdiff(DW'(pf1_q), DW'(phase_s1));
			dv_n  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			pf0_q <= '0;
			pf1_q <= '0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			// store in item order as each transaction leaves the wrap stage
			if (v_s1 && rdy2) begin
				if (freq_s1 == psh_pkg::FREQ_ZERO) begin
					pf0_q <= phase_s1;
				end else if (freq_s1 == psh_pkg::FREQ_ONE) begin
					pf1_q <= phase_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			phase_s1 <= zero_in ? '0 : zw[PHASE_BITS:0];
			freq_s1  <= freq_in;
		end
		if (rdy2 && v_s1) begin
			phase_s2 <= phase_s1;
			d12_s2   <= d12_n;
			d23_s2   <= d23_n;
			dv_s2    <= dv_n;
		end
		if (rdy3 && v_s2) begin
			phase_s3 <= phase_s2;
			d12_s3   <= d12_s2;
			d23_s3   <= d23_s2;
			dall_s3  <= dv_s2 ? hdiff(DW'({2'b00, d12_s2}), DW'({2'b00, d23_s2})) : '0;
			dv_s3    <= dv_s2;
		end
	end

endmodule

>>> tb/phase_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_result_checker: result prediction and comparison for the pixel core
// Watches the step-count write channel and both streams. Predicts every
// result from its own copy of the step count and the stored phases, then
// compares each result transaction field by field with the oldest one due.
// ----------------------------------------------------------------------------
module phase_result_checker
	import psh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  steps_t     cfg_data,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [71:0] s_tdata,
	input  logic [1:0] s_tuser,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [71:0] m_tdata,
	input  logic       m_tuser,
	output int         mismatch_count,
	output int         results_pending,
	output int         results_checked
);

	localparam int SB   = SAMPLE_BITS_DEF;
	localparam int PB   = PHASE_BITS_DEF;
	localparam int ITER = CORDIC_ITER_DEF;
	localparam int IN_W = ((6 * SB + 7) / 8) * 8;
	localparam longint PI_CODE      = longint'(1) <<< (PB - 1);
	localparam longint HALF_PI_CODE = longint'(1) <<< (PB - 2);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [PB:0] wrapped_phase;
		logic [PB:0]        diff_one_two;
		logic [PB:0]        diff_two_three;
		logic [PB:0]        diff_all;
		logic               diffs_valid;
	} phase_result_t;

	steps_t        step_count_q;
	longint        phase_zero_q;
	longint        phase_one_q;
	phase_result_t phases_due [$];
	phase_result_t expected_now;
	phase_result_t observed_now;
	int            mismatches;
	int            checked;

	// Binary-angle atan2 through a fixed number of CORDIC rotations
	function automatic longint cordic_phase(input longint num, input longint den);
		longint x, y, z, t, dx, dy, step_angle;
		int i;
		x = den;
		y = num;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		// pre-rotate the left half plane by a quarter turn
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HALF_PI_CODE;
			end else begin
				x = -y;
				y = t;
				z = -HALF_PI_CODE;
			end
		end
		x = x <<< ITER;
		y = y <<< ITER;
		for (i = 0; i < ITER && i < ATAN_LEN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			step_angle = (ATAN_TURN32[i] + (longint'(1) <<< (31 - PB))) >>> (32 - PB);
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += step_angle;
			end else begin
				x -= dx;
				y += dy;
				z -= step_angle;
			end
		end
		if (z > PI_CODE)
			z -= 2 * PI_CODE;
		if (z <= -PI_CODE)
			z += 2 * PI_CODE;
		return z;
	endfunction

	function automatic longint wrap_difference(input longint a, input longint b);
		return (a > b) ? a - b : a - b + 2 * PI_CODE;
	endfunction

	function automatic phase_result_t predict_result(input logic [IN_W-1:0] data,
			input freq_t fi);
		longint smp [6];
		longint num, den, ph, d12, d23, d123;
		steps_t eff;
		phase_result_t r;
		int k;
		for (k = 0; k < 6; k++)
			smp[k] = longint'(data[k*SB +: SB]);
		// clamp the step count into the supported range
		if (step_count_q < STEPS_THREE)
			eff = STEPS_THREE;
		else if (step_count_q > STEPS_SIX)
			eff = STEPS_SIX;
		else
			eff = step_count_q;
		case (eff)
			STEPS_THREE: begin
				num = 2 * smp[1] - smp[0] - smp[2];
				den = smp[2] - smp[0];
			end
			STEPS_FOUR: begin
				num = smp[3] - smp[1];
				den = smp[0] - smp[2];
			end
			STEPS_FIVE: begin
				num = 2 * (smp[1] - smp[3]);
				den = 2 * smp[2] - smp[0] - smp[4];
			end
			default: begin
				num = smp[1] + smp[5] - 2 * smp[3];
				den = 2 * smp[2] - smp[0] - smp[4];
			end
		endcase
		ph = cordic_phase(num, den);
		r = '0;
		r.wrapped_phase = ph[PB:0];
		if (fi == FREQ_TWO) begin
			d12  = wrap_difference(phase_zero_q, phase_one_q);
			d23  = wrap_difference(phase_one_q, ph);
			d123 = wrap_difference(d12, d23);
			r.diff_one_two   = d12[PB:0];
			r.diff_two_three = d23[PB:0];
			r.diff_all       = d123[PB:0];
			r.diffs_valid    = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q = STEPS_RESET;
			phase_zero_q = 0;
			phase_one_q  = 0;
			mismatches   = 0;
			checked      = 0;
			phases_due.delete();
			mismatch_count  <= 0;
			results_pending <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				step_count_q = cfg_data;
			if (s_tvalid && s_tready) begin
				expected_now = predict_result(s_tdata, freq_t'(s_tuser));
				case (freq_t'(s_tuser))
					FREQ_ZERO: phase_zero_q = $signed(expected_now.wrapped_phase);
					FREQ_ONE:  phase_one_q  = $signed(expected_now.wrapped_phase);
					default: ;
				endcase
				phases_due.push_back(expected_now);
			end
			if (m_tvalid && m_tready) begin
				observed_now.wrapped_phase  = m_tdata[0 +: PB+1];
				observed_now.diff_one_two   = m_tdata[(PB+1) +: PB+1];
				observed_now.diff_two_three = m_tdata[2*(PB+1) +: PB+1];
				observed_now.diff_all       = m_tdata[3*(PB+1) +: PB+1];
				observed_now.diffs_valid    = m_tuser;
				if (phases_due.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: result transaction with none due: phase %0d",
							$time, observed_now.wrapped_phase);
					mismatches++;
				end else begin
					expected_now = phases_due.pop_front();
					checked++;
					if (observed_now.wrapped_phase !== expected_now.wrapped_phase ||
							observed_now.diff_one_two !== expected_now.diff_one_two ||
							observed_now.diff_two_three !== expected_now.diff_two_three ||
							observed_now.diff_all !== expected_now.diff_all ||
							observed_now.diffs_valid !== expected_now.diffs_valid) begin
						if (mismatches < REPORT_LIMIT) begin
							$display("%0t: mismatch on result %0d", $time, checked);
							$display("  expected phase %0d d12 %0d d23 %0d d123 %0d valid %0b",
								expected_now.wrapped_phase, expected_now.diff_one_two,
								expected_now.diff_two_three, expected_now.diff_all,
								expected_now.diffs_valid);
							$display("  actual   phase %0d d12 %0d d23 %0d d123 %0d valid %0b",
								observed_now.wrapped_phase, observed_now.diff_one_two,
								observed_now.diff_two_three, observed_now.diff_all,
								observed_now.diffs_valid);
						end
						mismatches++;
					end
				end
			end
			mismatch_count  <= mismatches;
			results_pending <= phases_due.size();
			results_checked <= checked;
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the heterodyne phase-shift pixel core
// Drives directed corner sample sets, then random pixel triples under each
// step-count setting, with random gaps on both streams and one long
// receiver stall. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import psh_pkg::*;

	localparam int SB   = SAMPLE_BITS_DEF;
	localparam int PB   = PHASE_BITS_DEF;
	localparam int ITER = CORDIC_ITER_DEF;
	localparam int IN_W  = ((6 * SB + 7) / 8) * 8;
	localparam int OUT_W = ((4 * (PB + 1) + 7) / 8) * 8;
	localparam int LATENCY         = ITER + 4;
	localparam int SETTLE_CYCLES   = LATENCY + 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int IDLE_LIMIT      = 2000;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int PHASE_COUNT     = 8;
	localparam int PRESSURE_PHASE  = 2;
	localparam logic [SB-1:0] S_MAX = {SB{1'b1}};

	// step-count codes outside the supported range
	localparam steps_t STEPS_CODE_ZERO  = 3'd0;
	localparam steps_t STEPS_CODE_TWO   = 3'd2;
	localparam steps_t STEPS_CODE_SEVEN = 3'd7;

	localparam int MODE_FULL    = 0;
	localparam int MODE_EXTREME = 1;
	localparam int MODE_NEAR    = 2;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	steps_t           cfg_data  = STEPS_RESET;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;
	logic [1:0]       s_tuser   = FREQ_ZERO;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	int mismatch_count;
	int results_pending;
	int results_checked;

	int     sets_sent;
	int     step_writes;
	int     idle_cycles;
	bit     sender_burst;
	bit     pressure_on;
	bit     hold_off_req;
	int     rx_gap;
	int     rx_count;
	bit     rx_burst;
	steps_t phase_steps [PHASE_COUNT];

	always #5 clk = ~clk;

	phase_shift_heterodyne_pixel_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	phase_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending),
		.results_checked (results_checked)
	);

	// Offer one sample set and hold it until the transaction completes
	task automatic send_set(input logic [SB-1:0] a, b, c, d, e, f, input freq_t fi);
		logic [IN_W-1:0] packed_set;
		int gap;
		packed_set = '0;
		packed_set[0*SB +: SB] = a;
		packed_set[1*SB +: SB] = b;
		packed_set[2*SB +: SB] = c;
		packed_set[3*SB +: SB] = d;
		packed_set[4*SB +: SB] = e;
		packed_set[5*SB +: SB] = f;
		if (sets_sent % 16 == 0)
			sender_burst = ($urandom_range(0, 3) == 0);
		gap = (sender_burst || pressure_on) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= packed_set;
		s_tuser  <= fi;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sets_sent++;
	endtask

	// Drain the core, then write the step count
	task automatic write_step_count(input steps_t value);
		s_tvalid <= 1'b0;
		while (results_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		step_writes++;
	endtask

	function automatic logic [SB-1:0] random_sample(input int mode, input int base);
		int v;
		case (mode)
			MODE_EXTREME: v = $urandom_range(0, 1) ? int'(S_MAX) : 0;
			MODE_NEAR: begin
				v = base + $urandom_range(0, 6) - 3;
				if (v < 0)
					v = 0;
				if (v > int'(S_MAX))
					v = int'(S_MAX);
			end
			default: v = $urandom_range(0, int'(S_MAX));
		endcase
		return v[SB-1:0];
	endfunction

	task automatic send_random_set(input freq_t fi);
		int mode, base, pick;
		pick = $urandom_range(0, 9);
		// mostly full range, some rail values, some nearly equal samples
		mode = (pick < 6) ? MODE_FULL : ((pick < 8) ? MODE_EXTREME : MODE_NEAR);
		base = $urandom_range(0, int'(S_MAX));
		send_set(random_sample(mode, base), random_sample(mode, base),
			random_sample(mode, base), random_sample(mode, base),
			random_sample(mode, base), random_sample(mode, base), fi);
	endtask

	task automatic run_random_phase(input steps_t value, input bit with_pressure);
		int start;
		write_step_count(value);
		pressure_on = with_pressure;
		if (with_pressure)
			hold_off_req = 1'b1;
		start = sets_sent;
		while (sets_sent - start < ITEMS_PER_PHASE) begin
			if ($urandom_range(0, 9) != 0) begin
				send_random_set(FREQ_ZERO);
				send_random_set(FREQ_ONE);
				send_random_set(FREQ_TWO);
			end else begin
				send_random_set(freq_t'($urandom_range(0, 3)));
			end
		end
		pressure_on = 1'b0;
		s_tvalid <= 1'b0;
	endtask

	// Receiver: random stall before each result, one long hold-off on request
	initial begin
		rx_count = 0;
		rx_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			if (rx_count % 16 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
			rx_gap = rx_burst ? 0 : $urandom_range(0, 7);
			if (rx_gap > 0) begin
				m_tready <= 1'b0;
				repeat (rx_gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			rx_count++;
		end
	end

	// Watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles, %0d results due",
					idle_cycles, results_pending);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		sets_sent    = 0;
		step_writes  = 0;
		idle_cycles  = 0;
		sender_burst = 1'b0;
		pressure_on  = 1'b0;
		hold_off_req = 1'b0;
		phase_steps  = '{STEPS_THREE, STEPS_SIX, STEPS_CODE_ZERO, STEPS_FIVE,
			STEPS_CODE_SEVEN, STEPS_FOUR, STEPS_CODE_TWO, STEPS_THREE};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Four steps after reset: y = s4 - s2, x = s1 - s3
		send_set(0, 0, 0, 0, 0, 0, FREQ_TWO);            // no earlier frequencies, zero vector
		send_set(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, FREQ_ZERO);
		send_set(0, S_MAX, S_MAX, 0, 0, S_MAX, FREQ_ONE);
		send_set(S_MAX, 0, 0, S_MAX, S_MAX, 0, FREQ_TWO);
		send_set(0, 2048, S_MAX, 2048, 0, 0, FREQ_ZERO); // angle of pi, wraps
		send_set(0, 2048, S_MAX, 2048, 0, 0, FREQ_ONE);
		send_set(0, 2048, S_MAX, 2048, 0, 0, FREQ_TWO);  // equal phases, full turn
		send_set(100, S_MAX, 100, 0, 7, 9, FREQ_THREE);  // must not touch stored phases
		send_set(100, 0, 100, S_MAX, 0, 0, FREQ_TWO);
		send_set(1, 1, 0, 0, 0, 0, FREQ_ZERO);
		send_set(0, 0, 1, 1, 0, 0, FREQ_ONE);
		send_set(S_MAX, 7, 0, 7, S_MAX, S_MAX, FREQ_TWO);

		// Three steps: unused samples at the rail
		write_step_count(STEPS_THREE);
		send_set(0, S_MAX, 0, S_MAX, S_MAX, S_MAX, FREQ_ZERO);
		send_set(S_MAX, 0, S_MAX, 0, S_MAX, 0, FREQ_ONE);
		send_set(0, 0, S_MAX, S_MAX, 0, S_MAX, FREQ_TWO);

		write_step_count(STEPS_FIVE);
		send_set(S_MAX, S_MAX, 0, 0, S_MAX, 0, FREQ_ZERO);
		send_set(0, 0, S_MAX, S_MAX, 0, S_MAX, FREQ_ONE);
		send_set(0, 2048, 0, 2048, 0, S_MAX, FREQ_TWO);

		write_step_count(STEPS_SIX);
		send_set(0, S_MAX, 0, 0, 0, S_MAX, FREQ_ZERO);
		send_set(S_MAX, 0, 0, S_MAX, S_MAX, 0, FREQ_ONE);
		send_set(0, 0, S_MAX, 0, 0, 0, FREQ_TWO);
		send_set(S_MAX, 0, S_MAX, 0, S_MAX, 0, FREQ_THREE);
		s_tvalid <= 1'b0;

		for (int p = 0; p < PHASE_COUNT; p++)
			run_random_phase(phase_steps[p], p == PRESSURE_PHASE);

		while (results_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d sample sets, %0d results compared, across %0d step-count writes",
			sets_sent, results_checked, step_writes);
		$display("covered all step counts, out-of-range codes, frequency three, one %0d-cycle stall",
			HOLD_OFF_CYCLES);
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				mismatch_count, results_pending);
			$display("status: fail");
		end
		$finish;
	end

endmodule
